// ----- src/pcap_pkg.sv -----
`default_nettype none

package pcap_pkg;

   localparam int CHANNELS_DEFAULT = 10;
   localparam int IDX_MAX_W        = 6;   // enough to index 64 channels
   localparam int CH_W             = 4;
   localparam int STAMP_W          = 32;
   localparam int TICK_W           = 8;
   localparam int PER_W            = 38;
   localparam int PROD_W           = STAMP_W + TICK_W;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [TICK_W-1:0] TICK_NS_RESET = 8'd50;
   localparam logic [PER_W-1:0]  PER_MAX       = {PER_W{1'b1}};

   typedef enum logic {
      CMD_EDGE = 1'b0,
      CMD_POLL = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [CH_W-1:0]     channel;
      logic [STAMP_W-1:0]  timestamp;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]     report_channel;
      logic [PER_W-1:0]    period_ns;
      logic [STAMP_W-1:0]  hit_count;
   } rsp_type;

   // Classified operation handed from the front to the back.
   typedef struct packed {
      cmd_type                cmd;
      logic [IDX_MAX_W-1:0]   idx;
      logic [STAMP_W-1:0]     stamp;
   } op_type;

endpackage

`default_nettype wire

// ----- src/pcap_fifo.sv -----
`default_nettype none

module pcap_fifo #(
   parameter int  DEPTH     = pcap_pkg::QUEUE_DEPTH,
   parameter type ITEM_TYPE = logic
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire ITEM_TYPE push_data,
   output logic          full,
   input  wire logic     pop,
   output ITEM_TYPE      pop_data,
   output logic          empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ITEM_TYPE         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full     = (count_ff == FULL_CNT);
      empty    = (count_ff == '0);
      pop_data = slot_ff[rd_ff];
      do_push  = push && !full;
      do_pop   = pop && !empty;
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/pcap_front.sv -----
`default_nettype none

module pcap_front #(
   parameter int CHANNELS = pcap_pkg::CHANNELS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire pcap_pkg::req_type req,
   output logic                   op_valid,
   output pcap_pkg::op_type       op
);

   import pcap_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             in_range;

   // Classify: polls take the round-robin pointer, edges their own channel.
   always_comb begin
      in_range = (int'(req.channel) < CHANNELS);
      ptr_in   = ptr_ff;
      op.cmd   = req.cmd;
      op.stamp = req.timestamp;
      op.idx   = IDX_MAX_W'(req.channel);
      op_valid = 1'b0;
      case (req.cmd)
         CMD_POLL: begin
            op.idx   = IDX_MAX_W'(ptr_ff);
            op_valid = accept;
            if (accept) begin
               ptr_in = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + IDX_W'(1);
            end
         end
         default: begin
            // drop edges on channels that do not exist
            op_valid = accept && in_range;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/pcap_back.sv -----
`default_nettype none

module pcap_back #(
   parameter int CHANNELS = pcap_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [pcap_pkg::TICK_W-1:0] tick_ns,
   input  wire logic                       op_valid,
   input  wire pcap_pkg::op_type           op,
   output logic                            op_pop,
   input  wire logic                       rsp_full,
   output logic                            rsp_push,
   output pcap_pkg::rsp_type               rsp
);

   import pcap_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // per-channel stores
   logic [STAMP_W-1:0] last_mem [CHANNELS];
   logic [STAMP_W-1:0] hits_mem [CHANNELS];
   logic [STAMP_W-1:0] hap_mem  [CHANNELS];
   logic [PER_W-1:0]   per_mem  [CHANNELS];
   logic [CHANNELS-1:0] seen_ff, polled_ff;

   logic               adv;
   logic [IDX_W-1:0]   ra0;

   // stage 1: store read data available
   logic               v1_ff;
   cmd_type            cmd1_ff;
   logic [IDX_W-1:0]   idx1_ff;
   logic [STAMP_W-1:0] stamp1_ff, last_rd_ff, hits_rd_ff, hap_rd_ff;

   // stage 2: scale, write period, report
   logic               v2_ff;
   cmd_type            cmd2_ff;
   logic [IDX_W-1:0]   idx2_ff;
   logic [STAMP_W-1:0] ticks2_ff, hits2_ff;
   logic               same2_ff;
   logic [PER_W-1:0]   per_rd_ff;

   logic               hit_wr, poll_wr, per_wr;
   logic [STAMP_W-1:0] hits_next, ticks_in;
   logic [PROD_W-1:0]  prod;
   logic [PER_W-1:0]   period;

   always_comb begin
      adv       = !rsp_full;
      op_pop    = adv && op_valid;
      ra0       = op.idx[IDX_W-1:0];
      hit_wr    = v1_ff && (cmd1_ff == CMD_EDGE);
      poll_wr   = v1_ff && (cmd1_ff == CMD_POLL);
      per_wr    = v2_ff && (cmd2_ff == CMD_EDGE);
      hits_next = hits_rd_ff + STAMP_W'(1);
      ticks_in  = stamp1_ff - last_rd_ff;
      prod      = PROD_W'(ticks2_ff) * PROD_W'(tick_ns);
      period    = (prod > PROD_W'(PER_MAX)) ? PER_MAX : prod[PER_W-1:0];
      rsp_push  = adv && v2_ff && (cmd2_ff == CMD_POLL);
      rsp.report_channel = CH_W'(idx2_ff);
      rsp.period_ns      = same2_ff ? '0 : per_rd_ff;
      rsp.hit_count      = hits2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         seen_ff   <= '0;
         polled_ff <= '0;
      end else if (adv) begin
         v1_ff <= op_valid;
         v2_ff <= v1_ff;
         if (hit_wr) begin
            seen_ff[idx1_ff] <= 1'b1;
         end
         if (poll_wr) begin
            polled_ff[idx1_ff] <= 1'b1;
         end
      end
   end

   // Whole pipeline advances together; reads pass same-cycle writes through.
   always_ff @(posedge clock) begin
      if (adv) begin
         cmd1_ff   <= op.cmd;
         idx1_ff   <= ra0;
         stamp1_ff <= op.stamp;
         last_rd_ff <= (hit_wr && idx1_ff == ra0) ? stamp1_ff :
                       (seen_ff[ra0] ? last_mem[ra0] : '0);
         hits_rd_ff <= (hit_wr && idx1_ff == ra0) ? hits_next :
                       (seen_ff[ra0] ? hits_mem[ra0] : '0);
         hap_rd_ff  <= (poll_wr && idx1_ff == ra0) ? hits_rd_ff :
                       (polled_ff[ra0] ? hap_mem[ra0] : '0);

         cmd2_ff   <= cmd1_ff;
         idx2_ff   <= idx1_ff;
         ticks2_ff <= ticks_in;
         hits2_ff  <= hits_rd_ff;
         same2_ff  <= (hap_rd_ff == hits_rd_ff);
         per_rd_ff <= (per_wr && idx2_ff == idx1_ff) ? period : per_mem[idx1_ff];

         if (hit_wr) begin
            last_mem[idx1_ff] <= stamp1_ff;
            hits_mem[idx1_ff] <= hits_next;
         end
         if (poll_wr) begin
            hap_mem[idx1_ff] <= hits_rd_ff;
         end
         if (per_wr) begin
            per_mem[idx2_ff] <= period;
         end
      end
   end

endmodule

`default_nettype wire

// ----- src/multichannel_pulse_period_capture_core.sv -----
`default_nettype none

// Multichannel pulse period capture. Push a transaction on req_* for each
// pulse edge (cmd = edge, channel, timestamp) or to poll (cmd = poll). An edge
// stores its timestamp, bumps the channel's wrapping hit count and records
// the period (timestamp delta modulo 2^32 times tick_ns, saturated to 38
// bits); edges on a channel at or above CHANNELS are dropped and return
// nothing. A poll returns one transaction on rsp_* for the next channel in
// round-robin order, starting at channel 0: the stored period, or zero when
// no edge hit that channel since its last poll, plus its hit count. One
// transaction per cycle is sustained in both directions while rsp_* is not
// backed up: a two-entry queue splits the classifying front end from a
// three-stage back end (issue, store read, scale and report) whose per-channel
// stores each take one read and one write per cycle. A poll result reaches
// rsp_* through a result queue. The timestamp, hit count and poll stores
// read as zero after reset with no clearing pass. Write tick_ns through
// csr_* only while the block is idle; it resets to 50.
module multichannel_pulse_period_capture_core #(
   parameter int CHANNELS = pcap_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire pcap_pkg::req_type           req_data,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output pcap_pkg::rsp_type                rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [pcap_pkg::TICK_W-1:0] csr_wr_data
);

   import pcap_pkg::*;

   logic [TICK_W-1:0] tick_ns_ff;
   logic              req_accept;
   logic              front_valid;
   op_type            front_op;
   logic              mid_full, mid_empty, mid_pop;
   op_type            mid_op;
   logic              out_push, out_full;
   rsp_type           out_rsp;

   // Hold the tick length; the user must write it only between bursts of traffic, the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ns_ff <= TICK_NS_RESET;
      end else if (csr_wr_en) begin
         tick_ns_ff <= csr_wr_data;
      end
   end

   assign req_full   = mid_full;
   assign req_accept = req_push && !mid_full;

   // Front end: classify each transaction and advance the poll pointer.
   pcap_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req      (req_data),
      .op_valid (front_valid),
      .op       (front_op)
   );

   // Decoupling queue between front and back end.
   pcap_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .ITEM_TYPE (op_type)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_op),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_op),
      .empty     (mid_empty)
   );

   // Back end: per-channel read-modify-write and period scaling.
   pcap_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .tick_ns  (tick_ns_ff),
      .op_valid (!mid_empty),
      .op       (mid_op),
      .op_pop   (mid_pop),
      .rsp_full (out_full),
      .rsp_push (out_push),
      .rsp      (out_rsp)
   );

   // Result queue: finished reports wait here while the consumer stalls.
   pcap_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .ITEM_TYPE (rsp_type)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

`default_nettype wire

// ----- src/pcap_checker.sv -----
`default_nettype none

module pcap_checker #(
   parameter int CHANNELS = pcap_pkg::CHANNELS_DEFAULT
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_full,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire pcap_pkg::rsp_type rsp_data
);

   import pcap_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

   logic [IDX_W-1:0] next_ch_ff, next_ch_in;
   logic             taken;

   always_comb begin
      taken      = rsp_pop && !rsp_empty;
      next_ch_in = next_ch_ff;
      if (taken) begin
         next_ch_in = (next_ch_ff == LAST_IDX) ? '0 : next_ch_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ch_ff <= '0;
      end else begin
         next_ch_ff <= next_ch_in;
      end
   end

   a_reset_drains: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed or vanished");

   a_round_robin: assert property (@(posedge clock) disable iff (reset)
      taken |-> rsp_data.report_channel == CH_W'(next_ch_ff))
      else $error("poll reported channel out of round-robin order");

endmodule

bind multichannel_pulse_period_capture_core pcap_checker #(
   .CHANNELS (CHANNELS)
) u_pcap_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire
